// ===== hdl/pbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbp_pkg;

  // fixed field widths of the request and result ports
  localparam int unsigned PageNumW  = 24;
  localparam int unsigned SlotOutW  = 2;
  localparam int unsigned StampW    = 32;

  // default geometry of the pool
  localparam int unsigned PoolSlotsDef  = 4;
  localparam int unsigned PageIdBitsDef = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } pbp_state_e;

endpackage

`default_nettype wire

// ===== hdl/page_buffer_pool_lru.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+-------------------------------------
// request   | in        | in_valid_i / in_stall_o  | page_number_i
// result    | out       | out_valid_o / out_stall_i| hit_o, slot_o, took_free_slot_o
//
// A request is taken in idle, then one slot is examined per cycle (tag compare, first
// free slot, smallest stamp), stopping early on a hit; the update state writes the
// directory and loads the result register. A new request is taken only once the last
// has left the update state. rst_ni clears the state, the used bits, the stamps, the
// access counter and the result valid; tags are left as they are. A stalled result
// holds the block in its update state but not the next request.
module page_buffer_pool_lru
  import pbp_pkg::*;
#(
  parameter int unsigned POOL_SLOTS   = PoolSlotsDef,
  parameter int unsigned PAGE_ID_BITS = PageIdBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [PageNumW-1:0] page_number_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     hit_o,
  output logic [SlotOutW-1:0]      slot_o,
  output logic                     took_free_slot_o
);

  localparam int unsigned IdxW = $clog2(POOL_SLOTS);

  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [PAGE_ID_BITS-1:0] tag_t;
  typedef logic [StampW-1:0]       stamp_t;

  // control
  pbp_state_e state_q, state_d;
  idx_t       scan_q, scan_d;

  // request context
  tag_t       page_q, page_d;
  stamp_t     stamp_q, stamp_d;
  stamp_t     counter_q, counter_d;

  // search results
  logic       hit_q, hit_d;
  idx_t       sel_q, sel_d;
  logic       free_found_q, free_found_d;
  idx_t       free_idx_q, free_idx_d;
  idx_t       best_idx_q, best_idx_d;
  stamp_t     best_stamp_q, best_stamp_d;

  // directory
  logic [POOL_SLOTS-1:0] used_q;
  tag_t                  tag_q   [POOL_SLOTS];
  stamp_t                stamp_arr_q [POOL_SLOTS];

  // result register
  logic       out_valid_q, out_valid_d;
  logic       out_hit_q, out_hit_d;
  idx_t       out_slot_q, out_slot_d;
  logic       out_free_q, out_free_d;

  logic       dir_wr;     // refresh the stamp of the selected slot
  logic       dir_fill;   // install the tag and mark the slot used

  logic       match;
  tag_t       page_in;
  logic [PageNumW+PAGE_ID_BITS-1:0] page_wide;
  logic [IdxW+SlotOutW-1:0]         slot_wide;

  // keep only the low PAGE_ID_BITS of the request, zero-extend if narrower
  assign page_wide = {{PAGE_ID_BITS{1'b0}}, page_number_i};
  assign page_in   = page_wide[PAGE_ID_BITS-1:0];

  assign match  = used_q[scan_q] && (tag_q[scan_q] == page_q);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    page_d       = page_q;
    stamp_d      = stamp_q;
    counter_d    = counter_q;
    hit_d        = hit_q;
    sel_d        = sel_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_hit_d    = out_hit_q;
    out_slot_d   = out_slot_q;
    out_free_d   = out_free_q;
    dir_wr       = 1'b0;
    dir_fill     = 1'b0;
    in_stall_o   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          // advance the access counter, saturating at all ones
          if (counter_q != '1) begin
            counter_d = counter_q + stamp_t'(1);
          end
          stamp_d      = (counter_q != '1) ? counter_q + stamp_t'(1) : counter_q;
          page_d       = page_in;
          scan_d       = '0;
          free_found_d = 1'b0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (match) begin
          hit_d   = 1'b1;
          sel_d   = scan_q;
          state_d = ST_UPDATE;
        end else begin
          if (!used_q[scan_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = scan_q;
          end
          // only a strictly smaller stamp displaces the candidate
          if (scan_q == '0 || stamp_arr_q[scan_q] < best_stamp_q) begin
            best_idx_d   = scan_q;
            best_stamp_d = stamp_arr_q[scan_q];
          end
          if (scan_q == idx_t'(POOL_SLOTS - 1)) begin
            hit_d   = 1'b0;
            sel_d   = free_found_d ? free_idx_d : best_idx_d;
            state_d = ST_UPDATE;
          end else begin
            scan_d = scan_q + idx_t'(1);
          end
        end
      end

      ST_UPDATE: begin
        // hold while the previous result is still stalled
        if (!out_valid_q || !out_stall_i) begin
          dir_wr      = 1'b1;
          dir_fill    = !hit_q;
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_slot_d  = sel_q;
          out_free_d  = !hit_q && free_found_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        stamp_arr_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
      if (dir_wr) begin
        stamp_arr_q[sel_q] <= stamp_q;
      end
      if (dir_fill) begin
        used_q[sel_q] <= 1'b1;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    page_q       <= page_d;
    stamp_q      <= stamp_d;
    hit_q        <= hit_d;
    sel_q        <= sel_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    out_hit_q    <= out_hit_d;
    out_slot_q   <= out_slot_d;
    out_free_q   <= out_free_d;
    if (dir_fill) begin
      tag_q[sel_q] <= page_q;
    end
  end

  // slot field carries the low two bits of the slot index
  assign slot_wide        = {{SlotOutW{1'b0}}, out_slot_q};
  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign slot_o           = slot_wide[SlotOutW-1:0];
  assign took_free_slot_o = out_free_q;

endmodule

`default_nettype wire
